// File: src/json_string_escaper_assert.svh
// ----------------------------------------------------------------------------
// json_string_escaper assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

// property that must hold in the same cycle
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// property checked in the cycle after the antecedent
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: src/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character codes and helpers shared by the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int unsigned MaxRun   = 6;
  localparam int unsigned CountW   = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;

  localparam logic [CfgIdxW-1:0] CfgEscDouble = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgEscSingle = 1'b1;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDel       = 8'h7F;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChUpperF    = 8'h46;
  localparam logic [7:0] ChUpperD    = 8'h44;

  typedef logic [MaxRun-1:0][7:0] run_bytes_t;

  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] second;
    logic [7:0] third;
    logic [1:0] held;
    logic [1:0] expected;
  } seq_state_t;

  typedef struct packed {
    run_bytes_t        bytes;
    logic [CountW-1:0] count;
  } enc_run_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (ChZero + {4'h0, d}) : (ChLowerA + {4'h0, d} - 8'd10);
  endfunction

  // letters for controls 08..0D: b t n v f r
  function automatic logic [7:0] ctrl_letter(input logic [7:0] c);
    case (c)
      8'h08:   ctrl_letter = 8'h62;
      8'h09:   ctrl_letter = 8'h74;
      8'h0A:   ctrl_letter = 8'h6E;
      8'h0B:   ctrl_letter = 8'h76;
      8'h0C:   ctrl_letter = 8'h66;
      8'h0D:   ctrl_letter = 8'h72;
      default: ctrl_letter = 8'h3F;
    endcase
  endfunction

endpackage

// File: src/json_string_escaper.sv
// First output byte: valid in the cycle after the input transfer.
// Throughput: one input byte per cycle for single-byte runs while out_stall_i is low;
// an escape run holds the input until its last byte leaves the one-byte output register.
// Bytes that only extend a pending UTF-8 sequence produce no output.
// Reset: asynchronous, clears the sequence state and the output run count (the run
// bytes are not reset), and sets escape_double to 1 and escape_single to 0.
// ----------------------------------------------------------------------------
// json_string_escaper
// Streaming escaper: UTF-8 bytes in, escaped JSON-style text out.
// ----------------------------------------------------------------------------
module json_string_escaper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jse_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   in_byte_i,
  input  logic                         string_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         run_last_o,
  output logic                         string_done_o
);
  import jse_pkg::*;

  logic              esc_double_q, esc_single_q;
  seq_state_t        seq_q, seq_d;
  enc_run_t          enc;
  run_bytes_t        run_q, run_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic              end_q, end_d;
  logic              in_xfer, out_xfer;

  jse_encode u_encode (
    .in_byte_i    (in_byte_i),
    .string_end_i (string_end_i),
    .esc_double_i (esc_double_q),
    .esc_single_i (esc_single_q),
    .st_i         (seq_q),
    .st_o         (seq_d),
    .run_o        (enc)
  );

  assign out_valid_o   = rem_q != '0;
  assign out_byte_o    = run_q[0];
  assign run_last_o    = rem_q == CountW'(1);
  assign string_done_o = run_last_o && end_q;
  assign out_xfer      = out_valid_o && !out_stall_i;
  assign in_stall_o    = !((rem_q == '0) || (run_last_o && !out_stall_i));
  assign in_xfer       = in_valid_i && !in_stall_o;

  always_comb begin
    run_d = run_q;
    rem_d = rem_q;
    end_d = end_q;
    if (out_xfer) begin
      run_d = {8'h00, run_q[MaxRun-1:1]};
      rem_d = rem_q - CountW'(1);
    end
    if (in_xfer && enc.count != '0) begin
      run_d = enc.bytes;
      rem_d = enc.count;
      end_d = string_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_double_q <= 1'b1;
      esc_single_q <= 1'b0;
      seq_q        <= '0;
      rem_q        <= '0;
      end_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgEscDouble: esc_double_q <= cfg_data_i[0];
          CfgEscSingle: esc_single_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        seq_q <= seq_d;
      end
      rem_q <= rem_d;
      end_q <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

  `include "json_string_escaper_assert.svh"

  `JSE_ASSERT_NOW(a_held_bound, seq_q.held != 2'd0, seq_q.held <= seq_q.expected, "pending sequence longer than announced")
  `JSE_ASSERT_NOW(a_done_last, string_done_o, run_last_o, "string end flagged before end of run")
  `JSE_ASSERT_NEXT(a_run_drain, out_xfer && !run_last_o, rem_q == $past(rem_q) - CountW'(1) && !in_stall_o == ($past(rem_q) == CountW'(2) && !out_stall_i), "run count did not step down")

endmodule

// File: src/jse_encode.sv
// ----------------------------------------------------------------------------
// jse_encode
// Maps one input byte plus the pending UTF-8 sequence to its escaped run
// (zero to six bytes) and the next sequence state.
// ----------------------------------------------------------------------------
module jse_encode (
  input  logic [7:0]          in_byte_i,
  input  logic                string_end_i,
  input  logic                esc_double_i,
  input  logic                esc_single_i,
  input  jse_pkg::seq_state_t st_i,
  output jse_pkg::seq_state_t st_o,
  output jse_pkg::enc_run_t   run_o
);
  import jse_pkg::*;

  logic [3:0][7:0] s;
  logic [1:0]      conts;
  logic            ok1, ok2, ok3;
  logic [20:0]     cp;
  logic            bad;
  run_bytes_t      uesc, badesc;

  always_comb begin
    s        = {8'h00, st_i.third, st_i.second, st_i.lead};
    s[st_i.held] = in_byte_i;
    conts    = (st_i.expected == 2'd0) ? 2'd1 : st_i.expected;
    ok1      = s[1][7:6] == 2'b10;
    ok2      = s[2][7:6] == 2'b10;
    ok3      = s[3][7:6] == 2'b10;
    case (conts)
      2'd1: begin
        cp  = {10'h000, s[0][4:0], s[1][5:0]};
        bad = !ok1;
      end
      2'd2: begin
        cp  = {5'h00, s[0][3:0], s[1][5:0], s[2][5:0]};
        bad = !(ok1 && ok2);
      end
      default: begin
        cp  = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        bad = !(ok1 && ok2 && ok3) || (cp[20:16] != 5'h00);
      end
    endcase
    uesc   = {hex_char(cp[3:0]), hex_char(cp[7:4]), hex_char(cp[11:8]),
              hex_char(cp[15:12]), ChLowerU, ChBackslash};
    badesc = {ChUpperD, ChUpperF, ChUpperF, ChUpperF, ChLowerU, ChBackslash};
  end

  always_comb begin
    st_o      = st_i;
    run_o     = '0;
    if (st_i.held != 2'd0) begin
      if (st_i.held == conts) begin
        run_o.bytes = bad ? badesc : uesc;
        run_o.count = CountW'(MaxRun);
        st_o.held   = 2'd0;
      end else if (string_end_i) begin
        for (int k = 0; k < 4; k++) begin
          if (k <= int'(st_i.held)) begin
            run_o.bytes[k] = s[k];
          end
        end
        run_o.count = {1'b0, st_i.held} + 3'd1;
        st_o.held   = 2'd0;
      end else begin
        st_o.second = s[1];
        st_o.third  = s[2];
        st_o.held   = st_i.held + 2'd1;
      end
    end else if (in_byte_i >= 8'hC0 && in_byte_i <= 8'hF7) begin
      if (string_end_i) begin
        run_o.bytes[0] = in_byte_i;
        run_o.count    = 3'd1;
      end else begin
        st_o.lead     = in_byte_i;
        st_o.held     = 2'd1;
        st_o.expected = (in_byte_i < 8'hE0) ? 2'd1 : ((in_byte_i < 8'hF0) ? 2'd2 : 2'd3);
      end
    end else if (in_byte_i == 8'h00) begin
      run_o.bytes[1:0] = {ChZero, ChBackslash};
      run_o.count      = 3'd2;
    end else if (in_byte_i >= 8'h08 && in_byte_i <= 8'h0D) begin
      run_o.bytes[1:0] = {ctrl_letter(in_byte_i), ChBackslash};
      run_o.count      = 3'd2;
    end else if (in_byte_i < 8'h20 || in_byte_i == ChDel) begin
      run_o.bytes[3:0] = {hex_char(in_byte_i[3:0]), hex_char(in_byte_i[7:4]),
                          ChLowerX, ChBackslash};
      run_o.count      = 3'd4;
    end else if (in_byte_i == ChBackslash ||
                 (in_byte_i == ChDquote && esc_double_i) ||
                 (in_byte_i == ChSquote && esc_single_i)) begin
      run_o.bytes[1:0] = {in_byte_i, ChBackslash};
      run_o.count      = 3'd2;
    end else if (in_byte_i >= 8'h80) begin
      run_o.bytes = badesc;
      run_o.count = CountW'(MaxRun);
    end else begin
      run_o.bytes[0] = in_byte_i;
      run_o.count    = 3'd1;
    end
  end

endmodule

// File: dv/tb_json_string_escaper.sv
// ----------------------------------------------------------------------------
// tb_json_string_escaper
// Self-checking bench for the streaming JSON string escaper. A queue of raw
// UTF-8 bytes feeds a bursty driver; every accepted byte runs through an
// in-bench escape model that queues the escaped bytes it should produce, and a
// monitor checks each output transfer against them under a random stall mix.
// ----------------------------------------------------------------------------
module tb_json_string_escaper;
  import jse_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongHold  = 200;
  localparam int unsigned MaxShown  = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       str_done;
  } esc_char_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = CfgEscDouble;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte    = 8'h00;
  logic       string_end = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  json_string_escaper dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_byte_i    (in_byte),
    .string_end_i (string_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .run_last_o   (run_last),
    .string_done_o(string_done)
  );

  // escape model state
  logic       esc_dq = 1'b1;
  logic       esc_sq = 1'b0;
  logic [7:0] seq_lead   = 8'h00;
  logic [7:0] seq_second = 8'h00;
  logic [7:0] seq_third  = 8'h00;
  logic [1:0] seq_held   = 2'd0;
  logic [1:0] seq_conts  = 2'd0;

  raw_byte_t raw_q[$];
  esc_char_t escaped_q[$];
  int        mismatches = 0;
  int        hold_req   = 0;

  // bit 8 marks string end
  logic [8:0] dir_items [27] = '{
    9'h000, 9'h008, 9'h009, 9'h00a, 9'h00b, 9'h00c, 9'h00d, 9'h01f, 9'h07f,
    9'h05c, 9'h022, 9'h027, 9'h080, 9'h0ff, 9'h17e,
    9'h0c0, 9'h080,
    9'h0f4, 9'h08f, 9'h0bf, 9'h0bf,
    9'h0e2, 9'h041, 9'h080,
    9'h1c3,
    9'h0e2, 9'h182
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] nib_ascii(input logic [3:0] d);
    return (d < 4'd10) ? ChZero + 8'(d) : ChLowerA + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] lead_for(input int conts);
    case (conts)
      1:       return 8'hc0 | 8'($urandom_range(0, 31));
      2:       return 8'he0 | 8'($urandom_range(0, 15));
      default: return 8'hf0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void push_byte(input logic [7:0] ch, input logic fin);
    raw_byte_t it;
    it.ch  = ch;
    it.fin = fin;
    raw_q.push_back(it);
  endfunction

  // Escaped bytes caused by one accepted input byte
  function automatic void escape_byte(input logic [7:0] c, input logic fin);
    logic [7:0]  run_q[$];
    logic [7:0]  s [4];
    logic [7:0]  letter;
    logic [1:0]  conts;
    logic [20:0] cp;
    logic        ok;
    esc_char_t   r;
    int          k;
    if (seq_held != 2'd0) begin
      s[0] = seq_lead;
      s[1] = seq_second;
      s[2] = seq_third;
      s[3] = 8'h00;
      s[seq_held] = c;
      conts = (seq_conts == 2'd0) ? 2'd1 : seq_conts;
      if (seq_held == conts) begin
        ok = (s[1][7:6] == 2'b10);
        if (conts > 2'd1) ok = ok && (s[2][7:6] == 2'b10);
        if (conts > 2'd2) ok = ok && (s[3][7:6] == 2'b10);
        case (conts)
          2'd1:    cp = {10'd0, s[0][4:0], s[1][5:0]};
          2'd2:    cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
          default: cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        endcase
        if (cp > 21'h00ffff) ok = 1'b0;
        if (ok) begin
          run_q = {ChBackslash, ChLowerU, nib_ascii(cp[15:12]), nib_ascii(cp[11:8]),
                   nib_ascii(cp[7:4]), nib_ascii(cp[3:0])};
        end else begin
          run_q = {ChBackslash, ChLowerU, ChUpperF, ChUpperF, ChUpperF, ChUpperD};
        end
        seq_held = 2'd0;
      end else if (fin) begin
        for (k = 0; k <= int'(seq_held); k++) run_q.push_back(s[k]);
        seq_held = 2'd0;
      end else begin
        seq_second = s[1];
        seq_third  = s[2];
        seq_held   = seq_held + 2'd1;
      end
    end else if (c >= 8'hc0 && c <= 8'hf7) begin
      if (fin) begin
        run_q = {c};
      end else begin
        seq_lead  = c;
        seq_held  = 2'd1;
        seq_conts = (c < 8'he0) ? 2'd1 : ((c < 8'hf0) ? 2'd2 : 2'd3);
      end
    end else if (c == 8'h00) begin
      run_q = {ChBackslash, ChZero};
    end else if (c >= 8'h08 && c <= 8'h0d) begin
      case (c)
        8'h08:   letter = "b";
        8'h09:   letter = "t";
        8'h0a:   letter = "n";
        8'h0b:   letter = "v";
        8'h0c:   letter = "f";
        default: letter = "r";
      endcase
      run_q = {ChBackslash, letter};
    end else if (c < 8'h20 || c == ChDel) begin
      run_q = {ChBackslash, ChLowerX, nib_ascii(c[7:4]), nib_ascii(c[3:0])};
    end else if (c == ChBackslash) begin
      run_q = {ChBackslash, ChBackslash};
    end else if (c == ChDquote && esc_dq) begin
      run_q = {ChBackslash, ChDquote};
    end else if (c == ChSquote && esc_sq) begin
      run_q = {ChBackslash, ChSquote};
    end else if (c >= 8'h80) begin
      run_q = {ChBackslash, ChLowerU, ChUpperF, ChUpperF, ChUpperF, ChUpperD};
    end else begin
      run_q = {c};
    end
    foreach (run_q[i]) begin
      r.ch       = run_q[i];
      r.run_last = (i == run_q.size() - 1);
      r.str_done = r.run_last && fin;
      escaped_q.push_back(r);
    end
  endfunction

  // Random strings: mostly well-formed text with some broken sequences and noise
  task automatic gen_text(input int min_bytes);
    logic [7:0] text_q[$];
    logic [7:0] seq [4];
    logic [7:0] b;
    int         made;
    int         kind;
    int         conts;
    int         k;
    made = 0;
    while (made < min_bytes) begin
      text_q.delete();
      repeat ($urandom_range(1, 12)) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          text_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end else if (kind < 48) begin
          text_q.push_back(8'($urandom_range(0, 8'h1f)));
        end else if (kind < 54) begin
          case ($urandom_range(0, 3))
            0:       b = ChBackslash;
            1:       b = ChDquote;
            2:       b = ChSquote;
            default: b = ChDel;
          endcase
          text_q.push_back(b);
        end else if (kind < 90) begin
          conts  = $urandom_range(1, 3);
          seq[0] = lead_for(conts);
          for (k = 1; k <= conts; k++) seq[k] = cont_byte();
          if (conts == 3 && $urandom_range(0, 1) == 1) begin
            seq[0]      = 8'hf0;
            seq[1][5:4] = 2'b00;
          end
          if (kind >= 80) begin
            k      = $urandom_range(1, conts);
            seq[k] = 8'($urandom_range(0, 255));
            if (seq[k][7:6] == 2'b10) seq[k][6] = 1'b1;
          end
          for (k = 0; k <= conts; k++) text_q.push_back(seq[k]);
        end else if (kind < 95) begin
          b = ($urandom_range(0, 1) == 1) ? cont_byte() : 8'hf8 | 8'($urandom_range(0, 7));
          text_q.push_back(b);
        end else begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      // sequence cut off by the string end
      if ($urandom_range(0, 5) == 0) begin
        conts = $urandom_range(1, 3);
        text_q.push_back(lead_for(conts));
        repeat ($urandom_range(0, conts - 1)) text_q.push_back(cont_byte());
      end
      foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
      made += text_q.size();
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (raw_q.size() != 0 || in_valid || escaped_q.size() != 0);
  endtask

  task automatic write_cfg(input logic dq, input logic sq);
    repeat (8) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgEscDouble;
    cfg_data <= dq;
    @(posedge clk_i);
    cfg_idx  <= CfgEscSingle;
    cfg_data <= sq;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    esc_dq = dq;
    esc_sq = sq;
  endtask

  // driver: bursts of transfers separated by random gaps
  raw_byte_t next_byte;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) escape_byte(in_byte, string_end);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || raw_q.size() == 0) begin
          if (gap_left != 0) gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else begin
          next_byte = raw_q.pop_front();
          in_valid   <= 1'b1;
          in_byte    <= next_byte.ch;
          string_end <= next_byte.fin;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  int         hold_seen  = 0;
  int         hold_left  = 0;
  int         mode_timer = 0;
  logic [1:0] stall_mode = 2'd0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b1;
    end else begin
      if (mode_timer == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        mode_timer <= $urandom_range(20, 80);
      end else begin
        mode_timer <= mode_timer - 1;
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= LongHold;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          2'd0:    out_stall <= 1'b0;
          2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
          2'd2:    out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // monitor and watchdog
  esc_char_t want;
  esc_char_t got;
  int        idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got = {out_byte, run_last, string_done};
        if (escaped_q.size() == 0) begin
          if (mismatches < MaxShown)
            $display("unexpected transfer: byte %h run_last %b string_done %b",
                     out_byte, run_last, string_done);
          mismatches++;
        end else begin
          want = escaped_q.pop_front();
          if (got !== want) begin
            if (mismatches < MaxShown)
              $display("mismatch: exp %h/%b/%b got %h/%b/%b", want.ch, want.run_last,
                       want.str_done, got.ch, got.run_last, got.str_done);
            mismatches++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  logic cfg_dq [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
  logic cfg_sq [4] = '{1'b1, 1'b0, 1'b0, 1'b1};

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_items[i]) push_byte(dir_items[i][7:0], dir_items[i][8]);
    wait_idle();
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(cfg_dq[ph], cfg_sq[ph]);
      @(negedge clk_i);
      gen_text(115);
      // long receiver hold while the sender keeps offering
      if (ph == 0 || ph == 2) hold_req++;
      wait_idle();
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
